// ===== design/olal_pkg.sv =====
// ----------------------------------------------------------------------------
// olal_pkg: shared definitions for the ordered array list
// Command codes, status codes, field widths and the control bundle that
// the top level broadcasts to the row of storage cells.
// ----------------------------------------------------------------------------
package olal_pkg;

   localparam int DATA_W = 32;
   localparam int POS_W  = 5;
   localparam int CMD_W  = 2;
   localparam int LEN_W  = 5;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

   localparam logic ST_DONE   = 1'b0;
   localparam logic ST_REJECT = 1'b1;

   // Capacity register value after reset.
   localparam logic [LEN_W-1:0] CAP_RESET = 5'd16;

   // Broadcast to every cell in the cycle an item is accepted.
   typedef struct packed {
      logic                     shift_up;
      logic                     shift_down;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } olal_ctl_type;

endpackage

// ===== design/olal_req_if.sv =====
// ----------------------------------------------------------------------------
// olal_req_if: command channel of the ordered array list
// Valid/ready handshake carrying one command item.
// ----------------------------------------------------------------------------
interface olal_req_if
   import olal_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         cmd;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output cmd, output position, output value, input ready);
   modport sink   (input valid, input cmd, input position, input value, output ready);
endinterface

// ===== design/olal_rsp_if.sv =====
// ----------------------------------------------------------------------------
// olal_rsp_if: result channel of the ordered array list
// Valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface olal_rsp_if
   import olal_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic                     status;
   logic signed [DATA_W-1:0] read_value;
   logic [LEN_W-1:0]         length;
   logic                     full_res;

   modport source (output valid, output status, output read_value, output length,
                   output full_res, input ready);
   modport sink   (input valid, input status, input read_value, input length,
                   input full_res, output ready);
endinterface

// ===== design/olal_cell.sv =====
// ----------------------------------------------------------------------------
// olal_cell: one storage slot of the ordered array list
// Holds one entry and, on a shift, takes the word of its lower or upper
// neighbor or the inserted value, depending on where it sits.
// ----------------------------------------------------------------------------
module olal_cell
   import olal_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic                     clock,
   input  olal_ctl_type             ctl,
   input  logic signed [DATA_W-1:0] lower_data,
   input  logic signed [DATA_W-1:0] upper_data,
   output logic signed [DATA_W-1:0] data
);

   // Slots past the reach of a position field always sit above it.
   localparam bit               BEYOND   = (INDEX > ((1 << POS_W) - 1));
   localparam logic [POS_W-1:0] SLOT_POS = BEYOND ? '1 : POS_W'(INDEX);

   logic                     above;
   logic                     at;
   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   assign above = BEYOND | (SLOT_POS > ctl.position);
   assign at    = !BEYOND & (SLOT_POS == ctl.position);

   always_comb begin
      data_in = data_ff;
      if (ctl.shift_up) begin
         if (above) begin
            data_in = lower_data;
         end else if (at) begin
            data_in = ctl.value;
         end
      end else if (ctl.shift_down) begin
         if (above || at) begin
            data_in = upper_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ===== design/ordered_array_list.sv =====
// ----------------------------------------------------------------------------
// ordered_array_list: bounded ordered list of signed words
// Insert, remove, read and clear by position over a row of storage cells
// that shift all entries together on the same clock edge.
// ----------------------------------------------------------------------------
//
//   channel   direction   handshake          carries
//   req_chan  in          valid / ready      cmd, position, value
//   rsp_chan  out         valid / ready      status, read_value, length, full_res
//   csr_*     in          csr_wr_en          capacity (5 bits)
//
// Every command is accepted and every cell moves on the same clock edge;
// its result sits in the output register on the next cycle. A new
// command is accepted in every cycle the output register is empty or
// being drained, so the sustained rate is one item per cycle.
// A stalled result holds the command channel off until it is taken.
// Reset clears the length, the capacity register (back to 16) and the
// output valid; the stored words are not cleared, since a word is only
// ever read below the length, and every such slot has been written.
//
module ordered_array_list
   import olal_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [LEN_W-1:0]   csr_wr_data,
   olal_req_if.sink           req_chan,
   olal_rsp_if.source         rsp_chan
);

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   // The largest length a 5-bit length can reach with this many slots.
   localparam logic [LEN_W-1:0] MAX_CAP =
      (MAX_ENTRIES > ((1 << LEN_W) - 1)) ? '1 : LEN_W'(MAX_ENTRIES);

   // Configuration and list state.
   logic [LEN_W-1:0] cap_ff;
   logic [LEN_W-1:0] count_ff;
   logic [LEN_W-1:0] count_in;
   logic [LEN_W-1:0] eff_cap;

   // Output register.
   logic                     rsp_valid_ff;
   logic                     rsp_status_ff;
   logic                     rsp_status_in;
   logic signed [DATA_W-1:0] rsp_data_ff;
   logic signed [DATA_W-1:0] rsp_data_in;
   logic [LEN_W-1:0]         rsp_length_ff;
   logic                     rsp_full_ff;

   logic                     accept;
   logic                     ins_ok;
   logic                     pos_valid;
   logic signed [DATA_W-1:0] hit_data;
   olal_ctl_type             ctl;

   logic signed [DATA_W-1:0] cell_data [MAX_ENTRIES];

   // Capacity above the number of slots falls back to the number of slots.
   assign eff_cap = (cap_ff > MAX_CAP) ? MAX_CAP : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else if (csr_wr_en) begin
         cap_ff <= csr_wr_data;
      end
   end

   // The command channel is open whenever the result slot is free or
   // is being emptied in this cycle.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   // An insert may land anywhere from the head up to just past the tail,
   // and only while there is room. Remove and read need an existing entry.
   assign ins_ok    = (count_ff < eff_cap) && (req_chan.position <= count_ff);
   assign pos_valid = ({1'b0, req_chan.position} < {1'b0, count_ff});

   assign ctl.shift_up   = accept && (req_chan.cmd == CMD_INSERT) && ins_ok;
   assign ctl.shift_down = accept && (req_chan.cmd == CMD_REMOVE) && pos_valid;
   assign ctl.position   = req_chan.position;
   assign ctl.value      = req_chan.value;

   // Row of cells: each takes from its lower neighbor on an insert and
   // from its upper neighbor on a remove. The ends are tied to zero; the
   // words they bring in lie beyond the length and are never read.
   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      logic signed [DATA_W-1:0] lower_data;
      logic signed [DATA_W-1:0] upper_data;

      if (i == 0) begin : g_head
         assign lower_data = '0;
      end else begin : g_mid_lo
         assign lower_data = cell_data[i-1];
      end
      if (i == MAX_ENTRIES - 1) begin : g_tail
         assign upper_data = '0;
      end else begin : g_mid_hi
         assign upper_data = cell_data[i+1];
      end

      olal_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .lower_data (lower_data),
         .upper_data (upper_data),
         .data       (cell_data[i])
      );
   end

   // A read only uses this word when the position is below the length,
   // which keeps the select inside the row.
   assign hit_data = cell_data[IDX_W'(req_chan.position)];

   always_comb begin
      count_in      = count_ff;
      rsp_status_in = ST_DONE;
      rsp_data_in   = '0;
      case (req_chan.cmd)
         CMD_INSERT: begin
            if (ins_ok) begin
               count_in = count_ff + 1'b1;
            end else begin
               rsp_status_in = ST_REJECT;
            end
         end
         CMD_REMOVE: begin
            if (pos_valid) begin
               count_in = count_ff - 1'b1;
            end else begin
               rsp_status_in = ST_REJECT;
            end
         end
         CMD_READ: begin
            if (pos_valid) begin
               rsp_data_in = hit_data;
            end else begin
               rsp_status_in = ST_REJECT;
            end
         end
         CMD_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload; full is judged against the capacity in force now.
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_length_ff <= count_in;
         rsp_full_ff   <= (count_in >= eff_cap);
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.read_value = rsp_data_ff;
   assign rsp_chan.length     = rsp_length_ff;
   assign rsp_chan.full_res   = rsp_full_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------

   // The length never runs past the number of slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CAP)
      else $error("list length exceeds the number of slots");

   // A clear leaves an empty list and reports length zero.
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.cmd == CMD_CLEAR) |=>
         (rsp_valid_ff && rsp_length_ff == '0 && count_ff == '0))
      else $error("clear did not empty the list");

   // A rejected command leaves the length untouched.
   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && rsp_status_in == ST_REJECT) |=> (count_ff == $past(count_ff)))
      else $error("rejected command changed the length");

   // The reported length always matches the list after the command.
   a_length_tracks: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_length_ff == count_ff))
      else $error("reported length differs from the stored length");

endmodule

// ===== test/ordered_array_list_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_array_list_test: self-checking bench for the ordered array list
// A short scripted sequence covers the empty list, the extremes of the fields,
// every command and the capacity corner cases. Many random phases follow,
// each with a new capacity. A shadow list predicts every result. Traffic
// on both channels is bursty, with one long stall on the result side.
// ----------------------------------------------------------------------------
module ordered_array_list_test;
   import olal_pkg::*;

   localparam int LIST_DEPTH      = 16;
   localparam int PHASES          = 12;
   localparam int ITEMS_PER_PHASE = 96;
   localparam int PRESSURE_PHASE  = 2;
   localparam int DIRECTED_ROWS   = 28;
   localparam int REPORT_LIMIT    = 10;
   localparam int DRAIN_LIMIT     = 20000;

   // Capacity of each random phase. The list is never cleared between
   // phases, so a small capacity that follows a large one lands below the
   // current length. The list covers zero, one, the top of the list and
   // values past it.
   localparam int PHASE_CAPACITY [PHASES] = '{16, 5, 16, 0, 12, 31, 1, 16, 17, 3, 16, 8};

   // One result item, laid out in the order of the result channel.
   typedef struct packed {
      logic                     status;
      logic signed [DATA_W-1:0] read_value;
      logic [LEN_W-1:0]         length;
      logic                     full_res;
   } list_result_type;

   typedef enum logic {ROW_ITEM, ROW_CAPACITY} row_kind_type;

   // A row of the scripted sequence. For capacity rows, value holds the
   // new capacity. A row with has_want set is checked against the result
   // typed into the table. The shadow list checks all other rows.
   typedef struct packed {
      row_kind_type        kind;
      logic [CMD_W-1:0]    cmd;
      logic [POS_W-1:0]    pos;
      logic [DATA_W-1:0]   value;
      logic                has_want;
      list_result_type     want;
   } script_row_type;

   localparam script_row_type SCRIPT [DIRECTED_ROWS] = '{
      // Empty list: nothing to read or remove, and an insert past the end.
      '{ROW_ITEM, CMD_READ,   5'd0,  32'h0000_0000, 1'b1, '{ST_REJECT, 32'h0, 5'd0, 1'b0}},
      '{ROW_ITEM, CMD_REMOVE, 5'd0,  32'h0000_0000, 1'b1, '{ST_REJECT, 32'h0, 5'd0, 1'b0}},
      '{ROW_ITEM, CMD_INSERT, 5'd1,  32'h1234_5678, 1'b1, '{ST_REJECT, 32'h0, 5'd0, 1'b0}},
      // Extreme values, inserted at the front and at the end.
      '{ROW_ITEM, CMD_INSERT, 5'd0,  32'h7FFF_FFFF, 1'b1, '{ST_DONE, 32'h0, 5'd1, 1'b0}},
      '{ROW_ITEM, CMD_INSERT, 5'd0,  32'h8000_0000, 1'b1, '{ST_DONE, 32'h0, 5'd2, 1'b0}},
      '{ROW_ITEM, CMD_INSERT, 5'd2,  32'hFFFF_FFFF, 1'b1, '{ST_DONE, 32'h0, 5'd3, 1'b0}},
      '{ROW_ITEM, CMD_READ,   5'd0,  32'h0000_0000, 1'b1, '{ST_DONE, 32'h8000_0000, 5'd3, 1'b0}},
      '{ROW_ITEM, CMD_READ,   5'd2,  32'h0000_0000, 1'b1, '{ST_DONE, 32'hFFFF_FFFF, 5'd3, 1'b0}},
      '{ROW_ITEM, CMD_READ,   5'd3,  32'h0000_0000, 1'b1, '{ST_REJECT, 32'h0, 5'd3, 1'b0}},
      // Insert in the middle of the list and remove at its head.
      '{ROW_ITEM, CMD_INSERT, 5'd1,  32'h5A5A_A5A5, 1'b0, '0},
      '{ROW_ITEM, CMD_REMOVE, 5'd0,  32'h0000_0000, 1'b0, '0},
      '{ROW_ITEM, CMD_READ,   5'd1,  32'h0000_0000, 1'b0, '0},
      // Largest position code, then clear with every data bit set.
      '{ROW_ITEM, CMD_READ,   5'd31, 32'hFFFF_FFFF, 1'b1, '{ST_REJECT, 32'h0, 5'd3, 1'b0}},
      '{ROW_ITEM, CMD_INSERT, 5'd31, 32'hFFFF_FFFF, 1'b1, '{ST_REJECT, 32'h0, 5'd3, 1'b0}},
      '{ROW_ITEM, CMD_CLEAR,  5'd31, 32'hFFFF_FFFF, 1'b1, '{ST_DONE, 32'h0, 5'd0, 1'b0}},
      // Capacity of two: the list fills, and a further insert bounces.
      '{ROW_CAPACITY, CMD_INSERT, 5'd0, 32'd2,      1'b0, '0},
      '{ROW_ITEM, CMD_INSERT, 5'd0,  32'h0000_0005, 1'b1, '{ST_DONE, 32'h0, 5'd1, 1'b0}},
      '{ROW_ITEM, CMD_INSERT, 5'd1,  32'hA5A5_A5A5, 1'b1, '{ST_DONE, 32'h0, 5'd2, 1'b1}},
      '{ROW_ITEM, CMD_INSERT, 5'd0,  32'h0000_0000, 1'b1, '{ST_REJECT, 32'h0, 5'd2, 1'b1}},
      // Capacity lowered below the length: the entries stay readable.
      '{ROW_CAPACITY, CMD_INSERT, 5'd0, 32'd1,      1'b0, '0},
      '{ROW_ITEM, CMD_READ,   5'd1,  32'h0000_0000, 1'b1, '{ST_DONE, 32'hA5A5_A5A5, 5'd2, 1'b1}},
      '{ROW_ITEM, CMD_REMOVE, 5'd1,  32'h0000_0000, 1'b1, '{ST_DONE, 32'h0, 5'd1, 1'b1}},
      '{ROW_ITEM, CMD_INSERT, 5'd0,  32'h0000_0000, 1'b1, '{ST_REJECT, 32'h0, 5'd1, 1'b1}},
      // Capacity zero: the list is always full.
      '{ROW_CAPACITY, CMD_INSERT, 5'd0, 32'd0,      1'b0, '0},
      '{ROW_ITEM, CMD_REMOVE, 5'd0,  32'h0000_0000, 1'b1, '{ST_DONE, 32'h0, 5'd0, 1'b1}},
      '{ROW_ITEM, CMD_INSERT, 5'd0,  32'h0000_0000, 1'b1, '{ST_REJECT, 32'h0, 5'd0, 1'b1}},
      // A capacity code past the list size is clipped to the list size.
      '{ROW_CAPACITY, CMD_INSERT, 5'd0, 32'd31,     1'b0, '0},
      '{ROW_ITEM, CMD_INSERT, 5'd0,  32'h0000_0000, 1'b1, '{ST_DONE, 32'h0, 5'd1, 1'b0}}
   };

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_wr_en;
   logic [LEN_W-1:0]   csr_wr_data;

   olal_req_if req_chan ();
   olal_rsp_if rsp_chan ();

   ordered_array_list #(
      .MAX_ENTRIES (LIST_DEPTH)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan)
   );

   always #5 clock = ~clock;

   // Shadow copy of the list and of the capacity register. It is updated
   // in the order in which the block accepts items.
   logic [DATA_W-1:0]  list_words [LIST_DEPTH];
   int                 list_len;
   logic [LEN_W-1:0]   list_cap;

   // Results still owed by the block, oldest first.
   list_result_type    expected_results [$];

   int                 mismatches;
   int                 items_sent;
   int                 results_seen;
   int                 rejects_seen;
   int                 full_seen;
   int                 longest_list;
   int                 caps_written;

   // The main process asks for a long hold-off by setting this. The
   // receiver takes the request and counts the stall down itself.
   int                 hold_off_request;

   // Applies one command to the shadow list and returns the result that
   // the block must give for it.
   function automatic list_result_type apply_command(input logic [CMD_W-1:0] cmd,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic [DATA_W-1:0] data);
      list_result_type r;
      int limit;
      int at;
      int i;
      r = '0;
      r.status = ST_DONE;
      limit = (int'(list_cap) > LIST_DEPTH) ? LIST_DEPTH : int'(list_cap);
      at = int'(pos);
      case (cmd)
         CMD_INSERT: begin
            if (list_len >= limit || at > list_len) begin
               r.status = ST_REJECT;
            end else begin
               for (i = list_len; i > at; i--) list_words[i] = list_words[i-1];
               list_words[at] = data;
               list_len++;
            end
         end
         CMD_REMOVE: begin
            if (at >= list_len) begin
               r.status = ST_REJECT;
            end else begin
               for (i = at; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
               list_len--;
            end
         end
         CMD_READ: begin
            if (at >= list_len) r.status = ST_REJECT;
            else r.read_value = list_words[at];
         end
         CMD_CLEAR: begin
            list_len = 0;
         end
         default: begin
            r.status = ST_DONE;
         end
      endcase
      r.length = LEN_W'(list_len);
      r.full_res = (list_len >= limit);
      if (list_len > longest_list) longest_list = list_len;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input list_result_type want,
                                  input list_result_type got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("%0t: %s: expected status=%0d value=%h length=%0d full=%0d",
                  $time, what, want.status, want.read_value, want.length, want.full_res);
         $display("%0t: %s: got      status=%0d value=%h length=%0d full=%0d",
                  $time, what, got.status, got.read_value, got.length, got.full_res);
      end
   endtask

   // Offers one command and holds it until the block takes it. Valid stays
   // high on return so that a following call continues the burst.
   task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                               input logic [DATA_W-1:0] data, input logic has_want,
                               input list_result_type want);
      list_result_type predicted;
      req_chan.valid    <= 1'b1;
      req_chan.cmd      <= cmd;
      req_chan.position <= pos;
      req_chan.value    <= data;
      do @(posedge clock); while (!req_chan.ready);
      predicted = apply_command(cmd, pos, data);
      expected_results.push_back(has_want ? want : predicted);
      items_sent++;
   endtask

   task automatic pause_sender(input int cycles);
      req_chan.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stops offering items and waits until every owed result has been taken.
   task automatic wait_until_drained();
      req_chan.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // The block is idle here, so the new capacity holds from the next item on.
   task automatic write_capacity(input logic [LEN_W-1:0] cap);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      list_cap = cap;
      caps_written++;
   endtask

   // Result side: checks every accepted result against the oldest owed one
   // and drives ready from a stall pattern that changes mode every so often.
   initial begin
      list_result_type got;
      list_result_type want;
      int hold_left;
      int mode_left;
      int stall_mode;
      hold_left = 0;
      mode_left = 0;
      stall_mode = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            got.status     = rsp_chan.status;
            got.read_value = rsp_chan.read_value;
            got.length     = rsp_chan.length;
            got.full_res   = rsp_chan.full_res;
            results_seen++;
            if (got.status == ST_REJECT) rejects_seen++;
            if (got.full_res) full_seen++;
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing owed", '0, got);
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status || got.read_value !== want.read_value ||
                   got.length !== want.length || got.full_res !== want.full_res) begin
                  report_mismatch("result mismatch", want, got);
               end
            end
         end
         if (hold_off_request != 0) begin
            hold_left = hold_off_request;
            hold_off_request = 0;
         end
         if (hold_left > 0) begin
            // Long stall: the output register fills and the block has to
            // push back on the command channel.
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left = $urandom_range(4, 60);
            end
            mode_left--;
            case (stall_mode)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_chan.ready <= ~rsp_chan.ready;
            endcase
         end
      end
   end

   // Command side: scripted rows first, then the random phases.
   initial begin
      logic [CMD_W-1:0]  cmd;
      logic [POS_W-1:0]  pos;
      logic [DATA_W-1:0] data;
      int roll;
      int insert_pct;
      int remove_pct;
      int clear_pct;
      int burst_left;
      int guard;

      reset             <= 1'b1;
      csr_wr_en         <= 1'b0;
      csr_wr_data       <= '0;
      req_chan.valid    <= 1'b0;
      req_chan.cmd      <= CMD_READ;
      req_chan.position <= '0;
      req_chan.value    <= '0;
      hold_off_request  = 0;
      mismatches = 0;
      items_sent = 0;
      results_seen = 0;
      rejects_seen = 0;
      full_seen = 0;
      longest_list = 0;
      caps_written = 0;
      list_len = 0;
      list_cap = CAP_RESET;
      foreach (list_words[i]) list_words[i] = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Scripted sequence. A capacity row waits until the block is idle.
      for (int n = 0; n < DIRECTED_ROWS; n++) begin
         if (SCRIPT[n].kind == ROW_CAPACITY) begin
            wait_until_drained();
            write_capacity(SCRIPT[n].value[LEN_W-1:0]);
         end else begin
            send_command(SCRIPT[n].cmd, SCRIPT[n].pos, SCRIPT[n].value,
                         SCRIPT[n].has_want, SCRIPT[n].want);
         end
      end

      // Random phases. Each phase has its own command mix. Inserts
      // dominate so that the list often reaches its capacity. Most
      // positions are legal for the current length, so that the shifts
      // act on real contents. The rest are drawn from the whole field.
      burst_left = 0;
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_until_drained();
         write_capacity(LEN_W'(PHASE_CAPACITY[phase]));
         insert_pct = $urandom_range(35, 60);
         remove_pct = $urandom_range(15, 30);
         clear_pct  = $urandom_range(1, 4);
         if (phase == PRESSURE_PHASE) begin
            // The receiver stalls for a long time while a long burst with
            // no gaps keeps pushing commands.
            hold_off_request = 150;
            burst_left = 60;
         end
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 8));
            end
            burst_left--;

            roll = $urandom_range(0, 99);
            if (roll < clear_pct) cmd = CMD_CLEAR;
            else if (roll < clear_pct + insert_pct) cmd = CMD_INSERT;
            else if (roll < clear_pct + insert_pct + remove_pct) cmd = CMD_REMOVE;
            else cmd = CMD_READ;

            if ($urandom_range(0, 9) == 0 || cmd == CMD_CLEAR) begin
               pos = POS_W'($urandom_range(0, 31));
            end else if (cmd == CMD_INSERT) begin
               pos = POS_W'($urandom_range(0, list_len));
            end else begin
               pos = (list_len == 0) ? '0 : POS_W'($urandom_range(0, list_len - 1));
            end

            case ($urandom_range(0, 7))
               0: data = 32'h7FFF_FFFF;
               1: data = 32'h8000_0000;
               2: data = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
               default: data = $urandom;
            endcase

            send_command(cmd, pos, data, 1'b0, '0);
         end
      end

      // All commands are in. Wait for the last results, with a limit, then
      // give a late extra result the chance to show up.
      req_chan.valid <= 1'b0;
      guard = 0;
      while (expected_results.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (8) @(posedge clock);
      if (expected_results.size() != 0) begin
         $display("%0d results never arrived", expected_results.size());
         mismatches += expected_results.size();
      end

      $display("Covered %0d commands and %0d results over %0d capacity writes.",
               items_sent, results_seen, caps_written);
      $display("Rejected: %0d, full flags: %0d, longest list: %0d, mismatches: %0d.",
               rejects_seen, full_seen, longest_list, mismatches);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Timeout guard. A correct run needs only a small part of this time.
   initial begin
      #5_000_000;
      $display("Timeout with %0d results still owed", expected_results.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
